// ===== src/ssi_pkg.sv =====
package ssi_pkg;

    // Sketch geometry
    localparam int PHYS_GROUPS    = 1024;
    localparam int VIRT_GROUPS    = 32;
    localparam int REGS_PER_GROUP = 128;
    localparam int ROWS           = 4;
    localparam int BUCKETS        = 1024;
    localparam int MAX_RHO        = 31;

    localparam int PG_W        = $clog2(PHYS_GROUPS);
    localparam int VG_W        = $clog2(VIRT_GROUPS);
    localparam int REG_W       = $clog2(REGS_PER_GROUP);
    localparam int ROW_W       = $clog2(ROWS);
    localparam int BKT_W       = $clog2(BUCKETS);
    localparam int RHO_W       = 5;
    localparam int RHO_ADDR_W  = PG_W + REG_W;
    localparam int RHO_DEPTH   = PHYS_GROUPS * REGS_PER_GROUP;
    localparam int SLOT_ADDR_W = ROW_W + BKT_W;
    localparam int SLOT_DEPTH  = ROWS * BUCKETS;
    localparam int SEED_W      = 14;

    // Estimator arithmetic: 2^-reg kept with 30 fraction bits
    localparam int FRAC_BITS = 30;
    localparam int SUM_W     = REG_W + FRAC_BITS + 1;
    localparam int NUM_W     = REG_W + FRAC_BITS + 16 + 1;

    localparam logic [31:0] ELEM_SEED_OFFSET = 32'd15417891;
    localparam logic [31:0] CARD_ONE         = 32'd65536;
    localparam logic [31:0] SAT32            = 32'hFFFF_FFFF;

    // Virtual-to-physical group mix table
    localparam logic [31:0] GROUP_MIX [0:31] = '{
        32'd2725628290, 32'd1444492164, 32'd1001369998, 32'd2291192083,
        32'd3632694421, 32'd3217476757, 32'd962572696,  32'd3523028760,
        32'd1564808096, 32'd1686744101, 32'd2572712615, 32'd186525479,
        32'd1267589045, 32'd2944996661, 32'd3807606838, 32'd2892595386,
        32'd1879920448, 32'd3800713281, 32'd4044617030, 32'd1088214349,
        32'd2912533710, 32'd4048616015, 32'd223249368,  32'd1094862426,
        32'd1603814236, 32'd3377932768, 32'd121561825,  32'd2119485156,
        32'd1642325476, 32'd1361943285, 32'd3238649846, 32'd992916862
    };

    typedef enum logic [2:0] {
        OUT_NONE     = 3'd0,
        OUT_UPDATED  = 3'd1,
        OUT_FILLED   = 3'd2,
        OUT_REPLACED = 3'd3,
        OUT_REFUSED  = 3'd4
    } t_outcome;

    // Classified item handed from front to back
    typedef struct packed {
        logic [31:0]           key;
        logic [15:0]           draw;
        logic [RHO_ADDR_W-1:0] rho_addr;
        logic [RHO_W-1:0]      rho;
        logic [BKT_W-1:0]      bucket;
    } t_job;

    localparam int FIFO_DEPTH = 2;

endpackage

// ===== src/ssi_front.sv =====
module ssi_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [79:0]                i_s_tdata,  // source_key, dest_element, random_draw
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ssi_pkg::SEED_W-1:0] i_cfg_data, // seed
    input  logic                       i_clearing,
    output logic                       o_push,
    output ssi_pkg::t_job              o_job,
    input  logic                       i_full
);
    import ssi_pkg::*;

    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'h85ebca6b;
    localparam logic [31:0] C4 = 32'hc2b2ae35;
    localparam logic [31:0] CN = 32'he6546b64;
    localparam logic [2:0]  LAST_STEP = 3'd5;

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} t_fstate;

    t_fstate             r_state;
    logic [2:0]          r_step;
    logic [31:0]         r_h1, r_h2, r_key;
    logic [15:0]         r_draw;
    logic [SEED_W-1:0]   r_seed;
    logic [31:0]         seed1, seed2, t_sum, rem;
    logic [5:0]          blen;
    logic [VG_W-1:0]     vg;
    logic [PG_W-1:0]     pg;
    logic [RHO_W-1:0]    rho;

    // One murmur round step; at most one multiply per step
    function automatic logic [31:0] hash_step(input logic [2:0] s, input logic [31:0] h,
                                              input logic [31:0] sd);
        logic [31:0] x;
        logic [31:0] y;
        x = h;
        y = sd ^ h;
        case (s)
            3'd0: x = h * C1;
            3'd1: x = {h[16:0], h[31:17]} * C2;
            3'd2: begin
                x = {y[18:0], y[31:19]};
                x = (x << 2) + x + CN;
                x = x ^ 32'd4;
            end
            3'd3: x = (h ^ (h >> 16)) * C3;
            3'd4: x = (h ^ (h >> 13)) * C4;
            3'd5: x = h ^ (h >> 16);
            default: x = h;
        endcase
        return x;
    endfunction

    assign seed1 = {{(32-SEED_W){1'b0}}, r_seed};
    assign seed2 = seed1 + ELEM_SEED_OFFSET;

    // Classify from finished hashes
    always_comb begin
        t_sum = r_h1 + r_h2;
        vg    = t_sum[VG_W-1:0];
        rem   = t_sum >> (VG_W + REG_W);
        blen  = '0;
        for (int i = 0; i < 32; i++) begin
            if (rem[i]) blen = 6'(i + 1);
        end
        if (blen > 6'(MAX_RHO))  rho = '0;
        else if (blen == '0)     rho = RHO_W'(MAX_RHO);
        else                     rho = RHO_W'(7'(MAX_RHO + 1) - 7'(blen));
        pg = PG_W'(GROUP_MIX[vg] ^ r_h1);
        o_job.key      = r_key;
        o_job.draw     = r_draw;
        o_job.rho_addr = {pg, t_sum[VG_W +: REG_W]};
        o_job.rho      = rho;
        o_job.bucket   = r_h1[BKT_W-1:0];
    end

    assign o_s_tready  = (r_state == F_IDLE) && !i_clearing;
    assign o_cfg_ready = 1'b1;
    assign o_push      = (r_state == F_PUSH) && !i_full;

    // Sequencer and hash lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
            r_seed  <= '0;
        end else begin
            if (i_cfg_valid) r_seed <= i_cfg_data;
            case (r_state)
                F_IDLE: begin
                    if (i_s_tvalid && o_s_tready) begin
                        r_key   <= i_s_tdata[31:0];
                        r_h1    <= i_s_tdata[31:0];
                        r_h2    <= i_s_tdata[63:32];
                        r_draw  <= i_s_tdata[79:64];
                        r_step  <= '0;
                        r_state <= F_HASH;
                    end
                end
                F_HASH: begin
                    r_h1   <= hash_step(r_step, r_h1, seed1);
                    r_h2   <= hash_step(r_step, r_h2, seed2);
                    r_step <= r_step + 3'd1;
                    if (r_step == LAST_STEP) r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== src/ssi_fifo.sv =====
module ssi_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssi_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output ssi_pkg::t_job o_data,
    output logic          o_empty
);
    import ssi_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(i_push && !o_full) - (PTR_W+1)'(i_pop && !o_empty);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> r_cnt == (PTR_W+1)'(FIFO_DEPTH))
        else $error("fifo count moved while full");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W+1)'(FIFO_DEPTH))
        else $error("fifo count beyond depth");
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty && !i_push |=> o_empty)
        else $error("fifo left empty without push");

endmodule

// ===== src/ssi_back.sv =====
module ssi_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  ssi_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [47:0]   o_m_tdata  // outcome, card_value, bucket_index, row_index, pad
);
    import ssi_pkg::*;

    localparam int CLR_W = $clog2(RHO_DEPTH);
    localparam int BIT_W = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] NUMER = NUM_W'(REGS_PER_GROUP) << (FRAC_BITS + 16);
    localparam logic [48:0] DRAW_LIMIT = 49'd65535 * 49'd65536;

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_CHECK, B_SUM, B_DIVSET, B_DIV, B_SCAN, B_LHS, B_COMMIT, B_OUT
    } t_bstate;

    logic [RHO_W-1:0]  rho_mem  [RHO_DEPTH];
    logic [31:0]       key_mem  [SLOT_DEPTH];
    logic [31:0]       card_mem [SLOT_DEPTH];

    t_bstate           r_state;
    t_job              r_job;
    logic [CLR_W-1:0]  r_clr;
    logic [REG_W:0]    r_cnt;
    logic              r_lag;
    logic [ROW_W-1:0]  r_lrow;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W:0]    r_rem;
    logic [BIT_W-1:0]  r_bit;
    logic [31:0]       r_q, r_est;
    logic              r_ovf;
    logic [RHO_W-1:0]  r_rho_q;
    logic [31:0]       r_key_q, r_card_q;
    logic              r_match, r_has_empty, r_has_min;
    logic [ROW_W-1:0]  r_match_row, r_vacant_row, r_min_row;
    logic [31:0]       r_match_card, r_min_card;
    logic [48:0]       r_lhs;
    t_outcome          r_outcome;
    logic [31:0]       r_card;
    logic [ROW_W-1:0]  r_row;

    logic [RHO_ADDR_W-1:0]  rho_ra, rho_wa;
    logic [RHO_W-1:0]       rho_wd;
    logic                   rho_we;
    logic [SLOT_ADDR_W-1:0] slot_ra, slot_wa;
    logic [31:0]            key_wd, card_wd;
    logic                   slot_we;
    logic                   sum_issue, scan_issue;
    logic [SUM_W-1:0]       term;
    logic [SUM_W:0]         d_rem;
    logic [1:0]             d_q;
    logic [32:0]            upd_card, rep_card;
    logic [BIT_W-1:0]       d_idx;

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (rho_we) rho_mem[rho_wa] <= rho_wd;
        r_rho_q <= rho_mem[rho_ra];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            key_mem[slot_wa]  <= key_wd;
            card_mem[slot_wa] <= card_wd;
        end
        r_key_q  <= key_mem[slot_ra];
        r_card_q <= card_mem[slot_ra];
    end

    assign sum_issue  = (r_cnt < (REG_W+1)'(REGS_PER_GROUP));
    assign scan_issue = (r_cnt < (REG_W+1)'(ROWS)) && !r_match;
    assign upd_card   = {1'b0, r_match_card} + {1'b0, r_est};
    assign rep_card   = {1'b0, r_min_card} + {1'b0, CARD_ONE};

    // Read addresses
    always_comb begin
        if (r_state == B_SUM)
            rho_ra = {r_job.rho_addr[RHO_ADDR_W-1:REG_W], r_cnt[REG_W-1:0]};
        else
            rho_ra = i_job.rho_addr;
        slot_ra = {r_cnt[ROW_W-1:0], r_job.bucket};
    end

    // Register weight 2^-v with 30 fraction bits
    always_comb begin
        term = '0;
        if (r_rho_q < RHO_W'(MAX_RHO) && r_rho_q <= RHO_W'(FRAC_BITS))
            term = SUM_W'(1) << (FRAC_BITS - int'(r_rho_q));
    end

    // Two restoring division steps per cycle
    always_comb begin
        d_rem = r_rem;
        d_q   = '0;
        for (int j = 0; j < 2; j++) begin
            d_idx = r_bit - BIT_W'(j);
            d_rem = {d_rem[SUM_W-1:0], NUMER[d_idx]};
            if (d_rem >= {1'b0, r_sum}) begin
                d_rem    = d_rem - {1'b0, r_sum};
                d_q[1-j] = 1'b1;
            end
        end
    end

    // Memory writes: clearing pass or commit
    always_comb begin
        rho_we  = 1'b0;
        rho_wa  = r_job.rho_addr;
        rho_wd  = r_job.rho;
        slot_we = 1'b0;
        slot_wa = {r_match_row, r_job.bucket};
        key_wd  = r_job.key;
        card_wd = '0;
        if (r_state == B_CLEAR) begin
            rho_we  = 1'b1;
            rho_wa  = RHO_ADDR_W'(r_clr);
            rho_wd  = '0;
            slot_we = (r_clr < CLR_W'(SLOT_DEPTH));
            slot_wa = SLOT_ADDR_W'(r_clr);
            key_wd  = '0;
        end else if (r_state == B_COMMIT) begin
            if (r_match) begin
                rho_we  = 1'b1;
                slot_we = 1'b1;
                card_wd = upd_card[32] ? SAT32 : upd_card[31:0];
            end else if (r_has_empty) begin
                rho_we  = 1'b1;
                slot_we = 1'b1;
                slot_wa = {r_vacant_row, r_job.bucket};
                card_wd = r_est;
            end else if (r_has_min && r_lhs <= DRAW_LIMIT) begin
                rho_we  = 1'b1;
                slot_we = 1'b1;
                slot_wa = {r_min_row, r_job.bucket};
                card_wd = rep_card[32] ? SAT32 : rep_card[31:0];
            end
        end
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign o_m_tvalid = (r_state == B_OUT);
    assign o_m_tdata  = {1'b0, r_row, r_job.bucket, r_card, r_outcome};

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_W'(RHO_DEPTH - 1)) r_state <= B_IDLE;
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_state <= B_CHECK;
                    end
                end
                B_CHECK: begin
                    r_cnt <= '0;
                    r_lag <= 1'b0;
                    r_sum <= '0;
                    if (r_job.rho > r_rho_q) begin
                        r_state <= B_SUM;
                    end else begin
                        r_outcome <= OUT_NONE;
                        r_card    <= '0;
                        r_row     <= '0;
                        r_state   <= B_OUT;
                    end
                end
                B_SUM: begin
                    if (sum_issue) r_cnt <= r_cnt + 1'b1;
                    r_lag <= sum_issue;
                    if (r_lag) r_sum <= r_sum + term;
                    if (!sum_issue && !r_lag) r_state <= B_DIVSET;
                end
                B_DIVSET: begin
                    r_rem <= '0;
                    r_bit <= BIT_W'(NUM_W - 1);
                    r_q   <= '0;
                    r_ovf <= 1'b0;
                    r_cnt <= '0;
                    r_lag <= 1'b0;
                    r_match     <= 1'b0;
                    r_has_empty <= 1'b0;
                    r_has_min   <= 1'b0;
                    if (r_sum == '0) begin
                        r_est   <= SAT32;
                        r_state <= B_SCAN;
                    end else begin
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem <= d_rem;
                    r_q   <= {r_q[29:0], d_q};
                    if ((d_q[1] && r_bit >= BIT_W'(32)) || (d_q[0] && r_bit >= BIT_W'(33)))
                        r_ovf <= 1'b1;
                    r_bit <= r_bit - BIT_W'(2);
                    if (r_bit == BIT_W'(1)) begin
                        r_est   <= (r_ovf || (d_q[1] && r_bit >= BIT_W'(32))) ? SAT32
                                   : {r_q[29:0], d_q};
                        r_state <= B_SCAN;
                    end
                end
                B_SCAN: begin
                    if (scan_issue) r_cnt <= r_cnt + 1'b1;
                    r_lag  <= scan_issue;
                    r_lrow <= r_cnt[ROW_W-1:0];
                    if (r_lag && !r_match) begin
                        if (r_key_q == '0) begin
                            r_has_empty  <= 1'b1;
                            r_vacant_row <= r_lrow;
                        end else if (r_key_q == r_job.key) begin
                            r_match      <= 1'b1;
                            r_match_row  <= r_lrow;
                            r_match_card <= r_card_q;
                        end else if (!r_has_min || r_card_q < r_min_card) begin
                            r_has_min  <= 1'b1;
                            r_min_row  <= r_lrow;
                            r_min_card <= r_card_q;
                        end
                    end
                    if (!scan_issue && !r_lag) r_state <= B_LHS;
                end
                B_LHS: begin
                    r_lhs   <= 49'(r_job.draw) * ({17'b0, r_min_card} + 49'(CARD_ONE));
                    r_state <= B_COMMIT;
                end
                B_COMMIT: begin
                    r_state <= B_OUT;
                    if (r_match) begin
                        r_outcome <= OUT_UPDATED;
                        r_card    <= upd_card[32] ? SAT32 : upd_card[31:0];
                        r_row     <= r_match_row;
                    end else if (r_has_empty) begin
                        r_outcome <= OUT_FILLED;
                        r_card    <= r_est;
                        r_row     <= r_vacant_row;
                    end else if (r_has_min && r_lhs <= DRAW_LIMIT) begin
                        r_outcome <= OUT_REPLACED;
                        r_card    <= rep_card[32] ? SAT32 : rep_card[31:0];
                        r_row     <= r_min_row;
                    end else begin
                        r_outcome <= r_has_min ? OUT_REFUSED : OUT_NONE;
                        r_card    <= '0;
                        r_row     <= '0;
                    end
                end
                B_OUT: begin
                    if (i_m_tready) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_outcome == OUT_NONE || r_outcome == OUT_REFUSED)
        |-> r_card == '0 && r_row == '0)
        else $error("no-touch result carries card or row");
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_pop)
        else $error("item taken during clearing pass");
    a_rho_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rho_we && !o_clearing |-> slot_we && r_state == B_COMMIT)
        else $error("rho written without slot update");

endmodule

// ===== src/spreader_sketch_insert.sv =====
// Flow: hash, FIFO hand-off, pop and rho check; when rho does not grow the result
//   follows the check. Otherwise register sum (one read per cycle), division (two
//   quotient bits per cycle), slot scan, compare, commit and result follow in order.
// Throughput: one item per back-end pass; the register sum dominates.
// Reset: synchronous active low; afterwards a clearing pass zeroes the rho and
//   slot memories, during which no item is accepted.
module spreader_sketch_insert (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [79:0]                i_s_tdata,  // source_key, dest_element, random_draw
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [47:0]                o_m_tdata,  // outcome, card_value, bucket_index,
                                                   // row_index, pad
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ssi_pkg::SEED_W-1:0] i_cfg_data  // seed
);
    import ssi_pkg::*;

    logic push, pop, full, empty, clearing;
    t_job push_job, pop_job;

    ssi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_clearing  (clearing),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full)
    );

    ssi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_empty (empty)
    );

    ssi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (pop_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== bench/tb_spreader_sketch_insert.sv =====
module tb_spreader_sketch_insert;
    timeunit 1ns;
    timeprecision 1ps;
    import ssi_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int N_PHASE     = 4;
    localparam int PHASE_ITEMS = 258;
    localparam int POOL_BKTS   = 3;
    localparam int POOL_KEYS   = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;   // source_key, dest_element, random_draw
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // outcome, card_value, bucket_index, row_index, pad
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [SEED_W-1:0] i_cfg_data = '0;

    spreader_sketch_insert dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    typedef struct {
        t_outcome    outcome;
        logic [31:0] card;
        logic [9:0]  bucket;
        logic [1:0]  row;
    } t_insert_res;

    // Shadow sketch state
    logic [4:0]  shadow_rho [RHO_DEPTH];
    logic [31:0] shadow_key [SLOT_DEPTH];
    logic [31:0] shadow_card [SLOT_DEPTH];
    logic [31:0] shadow_seed = '0;

    t_insert_res pending_q[$];
    int unsigned n_bad = 0, n_seen = 0, n_sent = 0, cycles = 0;
    int unsigned outcome_cnt [5];
    bit quiet = 1'b0;  // no idling stretch

    // Directed item, optional hand-written expectation
    logic        force_res;
    t_insert_res forced_res;

    logic [31:0] pool [POOL_BKTS*POOL_KEYS];

    function automatic logic [31:0] mm_hash(logic [31:0] w, logic [31:0] s);
        logic [31:0] k, h;
        k = w * 32'hcc9e2d51;
        k = {k[16:0], k[31:17]} * 32'h1b873593;
        h = s ^ k;
        h = {h[18:0], h[31:19]} * 32'd5 + 32'he6546b64;
        h ^= 32'd4;
        h ^= h >> 16;
        h *= 32'h85ebca6b;
        h ^= h >> 13;
        h *= 32'hc2b2ae35;
        h ^= h >> 16;
        return h;
    endfunction

    function automatic logic [31:0] card_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

    // Insert one packet into the shadow sketch, return the expected result
    function automatic t_insert_res sketch_insert(logic [31:0] key, logic [31:0] elem,
                                                  logic [15:0] draw);
        t_insert_res r;
        logic [31:0] h1, tsum, rem, est32, minv;
        logic [63:0] total, quot;
        int blen, rho, pg, reg_i, base, bkt, idx, vacant_row, min_row;
        h1    = mm_hash(key, shadow_seed);
        tsum  = h1 + mm_hash(elem, shadow_seed + ELEM_SEED_OFFSET);
        reg_i = (tsum >> 5) & 127;
        rem   = tsum >> 12;
        blen  = 0;
        while (rem != 0) begin
            blen++;
            rem >>= 1;
        end
        rho = (blen > MAX_RHO) ? 0 : (blen == 0) ? MAX_RHO : MAX_RHO + 1 - blen;
        pg   = (GROUP_MIX[tsum[4:0]] ^ h1) & (PHYS_GROUPS - 1);
        base = pg * REGS_PER_GROUP;
        bkt  = h1 & (BUCKETS - 1);
        r.outcome = OUT_NONE;
        r.card    = '0;
        r.bucket  = bkt[9:0];
        r.row     = '0;
        if (rho <= shadow_rho[base + reg_i]) return r;

        // group estimate in 16.16
        total = '0;
        for (int i = 0; i < REGS_PER_GROUP; i++)
            if (shadow_rho[base + i] < MAX_RHO && shadow_rho[base + i] <= FRAC_BITS)
                total += 64'd1 << (FRAC_BITS - shadow_rho[base + i]);
        if (total == 0) begin
            est32 = SAT32;
        end else begin
            quot  = (64'(REGS_PER_GROUP) << (FRAC_BITS + 16)) / total;
            est32 = (quot > 64'(SAT32)) ? SAT32 : quot[31:0];
        end

        // slot scan
        vacant_row = -1;
        min_row    = -1;
        minv       = '0;
        for (int i = 0; i < ROWS; i++) begin
            idx = i * BUCKETS + bkt;
            if (shadow_key[idx] == 0) begin
                vacant_row = i;
            end else if (shadow_key[idx] == key) begin
                shadow_card[idx] = card_add(shadow_card[idx], est32);
                shadow_rho[base + reg_i] = rho[4:0];
                r.outcome = OUT_UPDATED;
                r.card    = shadow_card[idx];
                r.row     = i[1:0];
                return r;
            end else if (min_row < 0 || shadow_card[idx] < minv) begin
                min_row = i;
                minv    = shadow_card[idx];
            end
        end
        if (vacant_row >= 0) begin
            idx = vacant_row * BUCKETS + bkt;
            shadow_key[idx]  = key;
            shadow_card[idx] = est32;
            shadow_rho[base + reg_i] = rho[4:0];
            r.outcome = OUT_FILLED;
            r.card    = est32;
            r.row     = vacant_row[1:0];
        end else if (64'(draw) * (64'(minv) + 64'(CARD_ONE)) <= 64'd65535 * 64'(CARD_ONE)) begin
            idx = min_row * BUCKETS + bkt;
            shadow_key[idx]  = key;
            shadow_card[idx] = card_add(minv, CARD_ONE);
            shadow_rho[base + reg_i] = rho[4:0];
            r.outcome = OUT_REPLACED;
            r.card    = shadow_card[idx];
            r.row     = min_row[1:0];
        end else begin
            r.outcome = OUT_REFUSED;
        end
        return r;
    endfunction

    // Keys that collide in a few buckets under the current seed
    function automatic void build_pool();
        logic [31:0] k;
        int target;
        for (int b = 0; b < POOL_BKTS; b++) begin
            target = $urandom_range(BUCKETS - 1);
            for (int j = 0; j < POOL_KEYS; j++) begin
                do k = $urandom(); while ((mm_hash(k, shadow_seed) & (BUCKETS - 1)) != target
                                          || k == 0);
                pool[b * POOL_KEYS + j] = k;
            end
        end
    endfunction

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 32);
    endfunction

    task automatic write_seed(logic [SEED_W-1:0] s);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_seed = 32'(s);
        i_cfg_valid <= 1'b0;
    endtask

    // Valid drops only while idling, so back-to-back items keep it high
    task automatic send_item(logic [31:0] key, logic [31:0] elem, logic [15:0] draw);
        while (idle_now()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {draw, elem, key};
        do @(posedge i_clk); while (!o_s_tready);
        pending_q.push_back(sketch_insert(key, elem, draw));
        if (force_res) begin
            pending_q[$].outcome = forced_res.outcome;
            pending_q[$].card    = forced_res.card;
            pending_q[$].row     = forced_res.row;
        end
        n_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Result side: stall at random, check each accepted item
    always @(posedge i_clk) begin
        t_insert_res want;
        if (o_m_tvalid && i_m_tready && i_rst_n) begin
            n_seen++;
            if (pending_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("result with nothing pending: %h", o_m_tdata);
            end else begin
                want = pending_q.pop_front();
                if (o_m_tdata[2:0] <= 3'd4) outcome_cnt[o_m_tdata[2:0]]++;
                if (o_m_tdata[2:0] != want.outcome || o_m_tdata[34:3] != want.card ||
                    o_m_tdata[44:35] != want.bucket || o_m_tdata[46:45] != want.row) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"mismatch: exp out=%0d card=%h bkt=%0d row=%0d, ",
                                  "got out=%0d card=%h bkt=%0d row=%0d"},
                                 want.outcome, want.card, want.bucket, want.row, o_m_tdata[2:0],
                                 o_m_tdata[34:3], o_m_tdata[44:35], o_m_tdata[46:45]);
                end
            end
        end
        i_m_tready <= !idle_now();
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_q.size());
            $display("status: fail");
            $finish;
        end
    end

    typedef struct {
        bit          from_pool;
        int          pidx;
        logic [31:0] key;
        logic [31:0] elem;
        logic [15:0] draw;
        bit          typed;
        t_outcome    outcome;
        logic [31:0] card;
        logic [1:0]  row;
    } t_stim;

    // Directed items under seed 0; pool keys share one bucket
    t_stim directed [] = '{
        // first insert after reset: empty group, estimate exactly 1.0, last row
        '{0, 0, 32'h0000_0001, 32'h0000_0000, 16'h0000, 1, OUT_FILLED, 32'h0001_0000, 2'd3},
        '{0, 0, 32'h0000_0001, 32'h0000_0000, 16'h0000, 1, OUT_NONE,   32'h0,         2'd0},
        '{0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF, 0, OUT_NONE, 0, 0},
        '{0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, OUT_NONE, 0, 0},
        '{0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 0, OUT_NONE, 0, 0},
        // zero key fills but never matches
        '{0, 0, 32'h0000_0000, 32'h1234_5678, 16'h8000, 0, OUT_NONE, 0, 0},
        '{0, 0, 32'h0000_0000, 32'h8765_4321, 16'h8000, 0, OUT_NONE, 0, 0},
        '{0, 0, 32'hAAAA_5555, 32'h5555_AAAA, 16'h5555, 0, OUT_NONE, 0, 0},
        // fill one bucket, then compete for it
        '{1, 0, 0, 32'h0000_0010, 16'h0000, 0, OUT_NONE, 0, 0},
        '{1, 1, 0, 32'h0000_0011, 16'h0000, 0, OUT_NONE, 0, 0},
        '{1, 2, 0, 32'h0000_0012, 16'h0000, 0, OUT_NONE, 0, 0},
        '{1, 3, 0, 32'h0000_0013, 16'h0000, 0, OUT_NONE, 0, 0},
        '{1, 4, 0, 32'h0000_0014, 16'hFFFF, 0, OUT_NONE, 0, 0},
        '{1, 4, 0, 32'h0000_0015, 16'h0000, 0, OUT_NONE, 0, 0},
        '{1, 5, 0, 32'h0000_0016, 16'h7FFF, 0, OUT_NONE, 0, 0},
        '{1, 0, 0, 32'h0000_0017, 16'h0001, 0, OUT_NONE, 0, 0},
        '{1, 1, 0, 32'hF000_0000, 16'hFFFF, 0, OUT_NONE, 0, 0},
        '{1, 2, 0, 32'h0F0F_0F0F, 16'h0000, 0, OUT_NONE, 0, 0},
        '{0, 0, 32'h8000_0000, 32'h0000_0001, 16'h0001, 0, OUT_NONE, 0, 0},
        '{0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFE, 0, OUT_NONE, 0, 0}
    };

    localparam logic [SEED_W-1:0] PHASE_SEED [N_PHASE] = '{14'd9999, 14'd1, 14'd0, 14'd4660};

    initial begin
        logic [31:0] k, e;
        logic [15:0] d;
        int sel;
        for (int i = 0; i < RHO_DEPTH; i++) shadow_rho[i] = '0;
        for (int i = 0; i < SLOT_DEPTH; i++) begin
            shadow_key[i]  = '0;
            shadow_card[i] = '0;
        end
        force_res = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_seed('0);
        build_pool();
        foreach (directed[i]) begin
            force_res          = directed[i].typed;
            forced_res.outcome = directed[i].outcome;
            forced_res.card    = directed[i].card;
            forced_res.row     = directed[i].row;
            send_item(directed[i].from_pool ? pool[directed[i].pidx] : directed[i].key,
                      directed[i].elem, directed[i].draw);
        end
        force_res = 1'b0;

        for (int p = 0; p < N_PHASE; p++) begin
            wait_drained();
            write_seed(p == 2 ? 14'($urandom_range(9999)) : PHASE_SEED[p]);
            build_pool();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                quiet = (p == 1 && n >= 60 && n < 200);
                sel = $urandom_range(99);
                // mostly colliding keys so rows fill and takeovers happen
                if (sel < 60)      k = pool[$urandom_range(POOL_BKTS * POOL_KEYS - 1)];
                else if (sel < 64) k = '0;
                else               k = $urandom();
                e = (sel % 7 == 0) ? 32'($urandom_range(3)) : $urandom();
                case ($urandom_range(5))
                    0:       d = 16'h0000;
                    1:       d = 16'hFFFF;
                    2:       d = 16'($urandom_range(255));
                    default: d = 16'($urandom());
                endcase
                send_item(k, e, d);
            end
            quiet = 1'b0;
        end

        wait_drained();
        repeat (400) @(posedge i_clk);
        $display("sent %0d items over %0d seeds, checked %0d results", n_sent, N_PHASE + 1,
                 n_seen);
        $display("outcomes none/updated/filled/replaced/refused: %0d/%0d/%0d/%0d/%0d",
                 outcome_cnt[0], outcome_cnt[1], outcome_cnt[2], outcome_cnt[3],
                 outcome_cnt[4]);
        if (n_bad == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", n_bad, pending_q.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
